>>> hdl/dld_pkg.sv
// ----------------------------------------------------------------------------
// Delimiter/length deframer package
// Shared widths, register codes and structs for the deframer modules.
// ----------------------------------------------------------------------------
package dld_pkg;

    localparam int BYTE_W     = 8;
    localparam int DELIM_W    = 32;
    localparam int OFF_W      = 4;
    localparam int MAXP_W     = 24;
    localparam int PLEN_W     = 32;
    localparam int LEN_W      = 25;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DELIMITER     = 2'd0,
        CFG_LENGTH_OFFSET = 2'd1,
        CFG_MAX_PAYLOAD   = 2'd2
    } cfg_addr_t;

    localparam logic [DELIM_W-1:0] DELIM_RST = '0;
    localparam logic [OFF_W-1:0]   OFF_RST   = 4'd4;
    localparam logic [MAXP_W-1:0]  MAXP_RST  = '1;

    typedef struct packed {
        logic [DELIM_W-1:0] delimiter_word;
        logic [OFF_W-1:0]   length_offset;
        logic [MAXP_W-1:0]  max_payload;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              frame_first;
        logic              frame_last;
        logic [LEN_W-1:0]  frame_length;
    } result_t;

endpackage

>>> hdl/dld_in_stage.sv
// ----------------------------------------------------------------------------
// Deframer input register
// Holds one received byte until the core consumes it.
// ----------------------------------------------------------------------------
module dld_in_stage (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [dld_pkg::BYTE_W-1:0] s_byte_in,
    input  logic                      take,
    output logic                      byte_valid,
    output logic [dld_pkg::BYTE_W-1:0] byte_data
);
    import dld_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign s_ready    = !valid_reg || take;
    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_byte_in;
        end
    end

endmodule

>>> hdl/dld_core.sv
// ----------------------------------------------------------------------------
// Deframer core
// Header window shift line, sync/length test and frame byte counter.
// ----------------------------------------------------------------------------
module dld_core #(
    parameter int HEADER_BYTES = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       fire,
    input  logic [dld_pkg::BYTE_W-1:0] byte_in,
    input  dld_pkg::cfg_t              cfg,
    output logic                       res_valid,
    output dld_pkg::result_t           res
);
    import dld_pkg::*;

    localparam int IDX_W  = $clog2(HEADER_BYTES);
    localparam int FILL_W = $clog2(HEADER_BYTES + 1);
    localparam int SUM_W  = IDX_W + 2;

    logic [BYTE_W-1:0] win_reg   [HEADER_BYTES];
    logic [BYTE_W-1:0] win_shift [HEADER_BYTES];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              in_frame_reg;
    logic              in_frame_next;
    logic [LEN_W-1:0]  left_reg;
    logic [LEN_W-1:0]  left_next;

    logic [FILL_W-1:0]  fill_inc;
    logic               full;
    logic [DELIM_W-1:0] delim;
    logic [PLEN_W-1:0]  plen;
    logic               hit;
    logic [LEN_W-1:0]   total;
    logic [LEN_W-1:0]   total_m1;

    // Window after taking the new byte: oldest at index 0
    always_comb begin
        for (int i = 0; i < HEADER_BYTES - 1; i++) begin
            win_shift[i] = win_reg[i+1];
        end
        win_shift[HEADER_BYTES-1] = byte_in;
    end

    assign fill_inc = fill_reg + 1'b1;
    assign full     = (fill_inc == FILL_W'(HEADER_BYTES));
    assign delim    = {win_shift[3], win_shift[2], win_shift[1], win_shift[0]};

    // Length field bytes wrap around the window end
    always_comb begin
        logic [SUM_W-1:0] sum;
        logic [IDX_W-1:0] idx;
        plen = '0;
        for (int k = 0; k < 4; k++) begin
            sum = SUM_W'(cfg.length_offset) + SUM_W'(k);
            if (sum >= SUM_W'(2 * HEADER_BYTES)) begin
                sum = sum - SUM_W'(2 * HEADER_BYTES);
            end else if (sum >= SUM_W'(HEADER_BYTES)) begin
                sum = sum - SUM_W'(HEADER_BYTES);
            end
            idx = sum[IDX_W-1:0];
            plen[k*BYTE_W +: BYTE_W] = win_shift[idx];
        end
    end

    assign hit = full && !in_frame_reg && (delim == cfg.delimiter_word)
                 && (plen <= PLEN_W'(cfg.max_payload));
    assign total    = LEN_W'(HEADER_BYTES) + LEN_W'(plen[MAXP_W-1:0]);
    assign total_m1 = total - 1'b1;

    always_comb begin
        fill_next     = fill_reg;
        in_frame_next = in_frame_reg;
        left_next     = left_reg;
        res_valid     = 1'b0;
        res           = '0;
        if (fire) begin
            if (in_frame_reg) begin
                // Emit the oldest byte; window lags the stream inside a frame
                res_valid      = 1'b1;
                res.frame_byte = win_shift[0];
                res.frame_last = (left_reg == LEN_W'(1));
                left_next      = left_reg - 1'b1;
                in_frame_next  = (left_reg != LEN_W'(1));
                fill_next      = FILL_W'(HEADER_BYTES - 1);
            end else if (!full) begin
                fill_next = fill_inc;
            end else begin
                // Full window: drop the oldest byte on a miss, start a frame on a hit
                fill_next = FILL_W'(HEADER_BYTES - 1);
                if (hit) begin
                    res_valid        = 1'b1;
                    res.frame_byte   = win_shift[0];
                    res.frame_first  = 1'b1;
                    res.frame_last   = (total_m1 == '0);
                    res.frame_length = total;
                    left_next        = total_m1;
                    in_frame_next    = (total_m1 != '0);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            for (int i = 0; i < HEADER_BYTES; i++) begin
                win_reg[i] <= win_shift[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            in_frame_reg <= 1'b0;
            left_reg     <= '0;
        end else begin
            fill_reg     <= fill_next;
            in_frame_reg <= in_frame_next;
            left_reg     <= left_next;
        end
    end

    a_frame_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        in_frame_reg |-> (left_reg != '0))
        else $error("in frame with no bytes left");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(HEADER_BYTES - 1))
        else $error("window fill out of range");

    a_frame_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_frame_reg) |-> (res_valid && !res.frame_first))
        else $error("frame step without a plain frame byte");

    a_first_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.frame_first) |-> (res.frame_length >= LEN_W'(HEADER_BYTES)))
        else $error("frame length shorter than header");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res_valid && res.frame_last) |=> !in_frame_reg)
        else $error("frame continues after last byte");

endmodule

>>> hdl/dld_out_stage.sv
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one frame byte with its markers until the downstream transfer.
// ----------------------------------------------------------------------------
module dld_out_stage (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  dld_pkg::result_t          res,
    output logic                      out_free,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [dld_pkg::BYTE_W-1:0] m_frame_byte,
    output logic                      m_frame_first,
    output logic                      m_frame_last,
    output logic [dld_pkg::LEN_W-1:0] m_frame_length
);
    import dld_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free       = !valid_reg || m_ready;
    assign m_valid        = valid_reg;
    assign m_frame_byte   = res_reg.frame_byte;
    assign m_frame_first  = res_reg.frame_first;
    assign m_frame_last   = res_reg.frame_last;
    assign m_frame_length = res_reg.frame_length;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

>>> hdl/delimiter_length_deframer.sv
// One received byte is taken per clock. The byte passes through an input
// register, then the combinational window test logic, then a result register,
// so a frame byte is registered in both of them on its way to the result port.
// The rate is one byte per clock; the sync/length compare on the header window
// sits between those two registers, and the input side stalls only when the
// result register is full and not being taken. Frame bytes leave
// delayed by HEADER_BYTES - 1 received bytes, so the tail of a frame is pushed
// out by the bytes that follow it. Write the configuration registers only while
// idle.
// ----------------------------------------------------------------------------
// Delimiter/length deframer top level
// Sync word hunt with length check; passes recognized frames byte by byte.
// ----------------------------------------------------------------------------
module delimiter_length_deframer #(
    parameter int HEADER_BYTES = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dld_pkg::BYTE_W-1:0]    s_byte_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dld_pkg::BYTE_W-1:0]    m_frame_byte,
    output logic                          m_frame_first,
    output logic                          m_frame_last,
    output logic [dld_pkg::LEN_W-1:0]     m_frame_length,
    input  logic                          cfg_wr_en,
    input  logic [dld_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [dld_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import dld_pkg::*;

    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              out_free;
    logic              step_fire;
    logic              res_valid;
    result_t           res;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_DELIMITER:     cfg_next.delimiter_word = cfg_wdata[DELIM_W-1:0];
                CFG_LENGTH_OFFSET: cfg_next.length_offset  = cfg_wdata[OFF_W-1:0];
                CFG_MAX_PAYLOAD:   cfg_next.max_payload    = cfg_wdata[MAXP_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delimiter_word <= DELIM_RST;
            cfg_reg.length_offset  <= OFF_RST;
            cfg_reg.max_payload    <= MAXP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Advance the core whenever a byte is held and the result slot can take output
    assign step_fire = byte_valid && out_free;

    dld_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_byte_in  (s_byte_in),
        .take       (step_fire),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    dld_core #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (step_fire),
        .byte_in   (byte_data),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    dld_out_stage u_out_stage (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (step_fire && res_valid),
        .res            (res),
        .out_free       (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_byte   (m_frame_byte),
        .m_frame_first  (m_frame_first),
        .m_frame_last   (m_frame_last),
        .m_frame_length (m_frame_length)
    );

endmodule

>>> dv/delimiter_length_deframer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimiter/length deframer testbench
// Streams well-formed, corrupted and noise byte sequences through the block
// under several register settings, predicts every frame byte with a software
// copy of the header window, and compares each result transfer in order.
// ----------------------------------------------------------------------------

class frame_scoreboard #(int HDR = 16);

    logic [7:0]         window [HDR];
    int unsigned        fill;
    bit                 in_frame;
    logic [24:0]        left;
    logic [31:0]        delim;
    logic [3:0]         len_off;
    logic [23:0]        max_len;
    dld_pkg::result_t   pending [$];
    int unsigned        errors;

    function new();
        foreach (window[i]) window[i] = 8'h00;
        fill     = 0;
        in_frame = 1'b0;
        left     = '0;
        delim    = dld_pkg::DELIM_RST;
        len_off  = dld_pkg::OFF_RST;
        max_len  = dld_pkg::MAXP_RST;
        errors   = 0;
    endfunction

    function void write_reg(logic [dld_pkg::CFG_ADDR_W-1:0] idx, logic [31:0] data);
        case (idx)
            dld_pkg::CFG_DELIMITER:     delim   = data;
            dld_pkg::CFG_LENGTH_OFFSET: len_off = data[3:0];
            dld_pkg::CFG_MAX_PAYLOAD:   max_len = data[23:0];
            default: ;
        endcase
    endfunction

    // Remove the oldest window byte and shift the rest down.
    function logic [7:0] take_oldest();
        logic [7:0] b;
        b = window[0];
        for (int i = 0; i < HDR - 1; i++) window[i] = window[i+1];
        window[HDR-1] = 8'h00;
        if (fill > 0) fill--;
        return b;
    endfunction

    function void note_input(logic [7:0] b);
        logic [31:0]      sync;
        logic [31:0]      plen;
        logic [31:0]      total;
        int               o;
        dld_pkg::result_t want;
        if (fill >= HDR) void'(take_oldest());
        window[fill] = b;
        fill++;
        if (in_frame) begin
            want.frame_byte   = take_oldest();
            if (left > 0) left--;
            want.frame_first  = 1'b0;
            want.frame_last   = (left == 0);
            want.frame_length = '0;
            if (left == 0) in_frame = 1'b0;
            pending.push_back(want);
            return;
        end
        if (fill < HDR) return;
        o    = int'(len_off);
        sync = {window[3], window[2], window[1], window[0]};
        // length bytes wrap around the window end
        plen = {window[(o + 3) % HDR], window[(o + 2) % HDR],
                window[(o + 1) % HDR], window[o % HDR]};
        if (sync == delim && plen <= {8'h00, max_len}) begin
            total             = HDR + plen;
            want.frame_byte   = take_oldest();
            left              = 25'(total - 1);
            in_frame          = (left != 0);
            want.frame_first  = 1'b1;
            want.frame_last   = (left == 0);
            want.frame_length = total[24:0];
            pending.push_back(want);
        end else begin
            void'(take_oldest());
        end
    endfunction

    function void check_result(dld_pkg::result_t got);
        dld_pkg::result_t want;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: byte %02h first %0b last %0b length %0d",
                         got.frame_byte, got.frame_first, got.frame_last,
                         got.frame_length);
            return;
        end
        want = pending.pop_front();
        if (got.frame_byte !== want.frame_byte || got.frame_first !== want.frame_first ||
            got.frame_last !== want.frame_last ||
            got.frame_length !== want.frame_length) begin
            errors++;
            if (errors <= 10)
                $display({"result mismatch: expected byte %02h first %0b last %0b ",
                          "length %0d, got byte %02h first %0b last %0b length %0d"},
                         want.frame_byte, want.frame_first, want.frame_last,
                         want.frame_length, got.frame_byte, got.frame_first,
                         got.frame_last, got.frame_length);
        end
    endfunction

endclass

module delimiter_length_deframer_test;
    import dld_pkg::*;

    localparam int HDR         = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_byte_in;
    logic                  m_valid;
    logic                  m_ready;
    logic [BYTE_W-1:0]     m_frame_byte;
    logic                  m_frame_first;
    logic                  m_frame_last;
    logic [LEN_W-1:0]      m_frame_length;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    frame_scoreboard #(HDR) sb;
    result_t               seen;
    bit                    idle_en;
    bit                    hold_req;
    int unsigned           bytes_sent;
    int unsigned           cycles = 0;

    assign seen = {m_frame_byte, m_frame_first, m_frame_last, m_frame_length};

    delimiter_length_deframer #(
        .HEADER_BYTES (HDR)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_byte_in      (s_byte_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_byte   (m_frame_byte),
        .m_frame_first  (m_frame_first),
        .m_frame_last   (m_frame_last),
        .m_frame_length (m_frame_length),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid && m_ready) sb.check_result(seen);
    end

    // Receiver: short random stalls, plus one long hold on request.
    initial begin
        int unsigned stall_left;
        m_ready    = 1'b0;
        stall_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 12);
            end
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge aclk);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap     = $urandom_range(1, 12);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_byte_in = b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(b);
        bytes_sent++;
    endtask

    // Drop valid and wait for every predicted byte to come out.
    task automatic settle(input int extra);
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = data;
        @(posedge aclk);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic configure(input logic [31:0] d, input logic [31:0] o,
                             input logic [31:0] m);
        write_cfg(CFG_DELIMITER, d);
        write_cfg(CFG_LENGTH_OFFSET, o);
        write_cfg(CFG_MAX_PAYLOAD, m);
    endtask

    // Header with the current sync word and requested length, then payload.
    // Length bytes that fall on the sync word keep the sync value.
    task automatic send_frame(input bit break_sync, input logic [31:0] want_len);
        logic [7:0]  hdr [HDR];
        logic [31:0] got_sync;
        logic [31:0] got_len;
        int          o;
        int          pos;
        int          flip;
        int unsigned n_pay;
        o = int'(sb.len_off);
        foreach (hdr[i]) hdr[i] = 8'($urandom);
        for (int k = 0; k < 4; k++) hdr[k] = sb.delim[8*k +: 8];
        for (int k = 0; k < 4; k++) begin
            pos = (o + k) % HDR;
            if (pos >= 4) hdr[pos] = want_len[8*k +: 8];
        end
        if (break_sync) begin
            flip      = $urandom_range(0, 3);
            hdr[flip] = hdr[flip] ^ (8'h01 << $urandom_range(0, 7));
        end
        got_sync = {hdr[3], hdr[2], hdr[1], hdr[0]};
        got_len  = {hdr[(o + 3) % HDR], hdr[(o + 2) % HDR],
                    hdr[(o + 1) % HDR], hdr[o % HDR]};
        foreach (hdr[i]) send_byte(hdr[i]);
        if (got_sync == sb.delim && got_len <= {8'h00, sb.max_len})
            n_pay = got_len;
        else
            n_pay = $urandom_range(0, 6);
        repeat (n_pay) send_byte(8'($urandom));
    endtask

    task automatic flush_frame();
        while (sb.in_frame) send_byte(8'($urandom));
    endtask

    task automatic run_phase(input int unsigned budget, input bit long_hold);
        int unsigned start;
        int unsigned pick;
        int unsigned cap;
        int unsigned short_cap;
        start     = bytes_sent;
        cap       = (sb.max_len < 200) ? sb.max_len : 200;
        short_cap = (cap < 16) ? cap : 16;
        // empty payload, payload at the limit capped at 40, bad sync, length just over
        // the limit and an all-ones length field
        send_frame(1'b0, 0);
        send_frame(1'b0, (sb.max_len < 40) ? sb.max_len : 40);
        send_frame(1'b1, $urandom_range(0, 8));
        send_frame(1'b0, sb.max_len + 1);
        send_frame(1'b0, 32'hFFFF_FFFF);
        if (long_hold) hold_req = 1'b1;
        while (bytes_sent - start < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                if ($urandom_range(0, 3) == 0)
                    send_frame(1'b0, $urandom_range(0, cap));
                else
                    send_frame(1'b0, $urandom_range(0, short_cap));
            end else if (pick < 82) begin
                send_frame(1'b1, $urandom_range(0, 16));
            end else if (pick < 90) begin
                send_frame(1'b0, sb.max_len + 1 + $urandom_range(0, 1000));
            end else begin
                repeat ($urandom_range(1, 20)) send_byte(8'($urandom));
            end
        end
        flush_frame();
    endtask

    initial begin
        logic [31:0] rnd;
        sb         = new();
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_byte_in  = '0;
        cfg_wr_en  = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        idle_en    = 1'b1;
        hold_req   = 1'b0;
        bytes_sent = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset values: an all-zero header is a frame with empty payload
        repeat (HDR) send_byte(8'h00);
        send_frame(1'b0, 3);
        flush_frame();
        settle(6);

        configure($urandom, 4, 32'h00FF_FFFF);
        run_phase(300, 1'b1);
        settle(6);

        configure(32'hFFFF_FFFF, 12, 0);
        run_phase(120, 1'b0);
        settle(6);

        // length field wraps past the window end; junk in the upper bits
        rnd = $urandom;
        configure({rnd[31:8], 8'h00}, 32'hFFFF_FFFD, 32'h5A00_012C);
        run_phase(180, 1'b0);
        settle(6);

        // length field overlaps the sync word
        idle_en = 1'b0;
        rnd     = $urandom;
        configure({8'h00, 8'($urandom_range(0, 30)), rnd[15:0]}, 2, 40);
        run_phase(150, 1'b0);
        settle(6);

        idle_en = 1'b1;
        configure(32'h0000_0000, 8, 1);
        write_cfg(CFG_SPARE, $urandom);
        run_phase(130, 1'b0);
        settle(6);

        configure($urandom_range(0, 40), 0, 40);
        run_phase(150, 1'b0);
        settle(6);

        idle_en = 1'b0;
        rnd     = $urandom;
        configure({rnd[7:0], 24'h00_0000}, 15, 200);
        run_phase(200, 1'b0);
        settle(20);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> delimiter_length_deframer.f
hdl/dld_pkg.sv
hdl/dld_in_stage.sv
hdl/dld_core.sv
hdl/dld_out_stage.sv
hdl/delimiter_length_deframer.sv
dv/delimiter_length_deframer_test.sv
